### sv/pidc_pkg.sv
// Shared types and constants for the clamped PID controller.
// Register indexes, field widths, reset values and the sequencer state type.
// No dependencies.
package pidc_pkg;

	// default internal precision, signed fixed point
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed port and register field widths
	localparam int GAIN_W     = 32;
	localparam int ERR_W      = 32;
	localparam int DRIVE_W    = 32;
	localparam int LIM_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;

	// register reset values
	localparam logic [LIM_W-1:0] TIME_STEP_RST   = 31'd655;
	localparam logic [LIM_W-1:0] INTEG_LIMIT_RST = 31'd327680000;
	localparam logic [LIM_W-1:0] DRIVE_LIMIT_RST = 31'd0;

	// request action codes
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL_DT,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_FINISH
	} state_t;

endpackage

### sv/pid_controller_clamped.sv
// Clamped PID controller: bit-serial multiplier, restoring divider and sequencer.
// Depends on pidc_pkg for widths, register indexes, codes and the state type.
// Step request: one divide, then four products (time step, P, I, D), at one quotient
//   bit and one multiplier bit per cycle. A new request is accepted only in idle,
//   after the previous step has handed its result to the output register.
// Clear request: goes straight to the finish step. Output register lets a request be
//   accepted while the previous result waits. Reset: registers to their reset
//   values, integrator and previous error to zero, no result pending.
module pid_controller_clamped #(
	parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic signed [pidc_pkg::ERR_W-1:0]      error_in,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pidc_pkg::DRIVE_W-1:0]    drive,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pidc_pkg::*;

	localparam int DW       = DATA_WIDTH;
	localparam int FB       = FRAC_BITS;
	localparam int PW       = GAIN_W + DW;               // full product width
	localparam int NW       = DW + FB;                   // dividend / quotient width
	localparam int XW       = ((DW > DRIVE_W) ? DW : DRIVE_W) + 1;
	localparam int MUL_LAST = GAIN_W + 1;
	localparam int CNT_TOP  = (NW > MUL_LAST) ? NW : MUL_LAST;
	localparam int CW       = $clog2(CNT_TOP + 1);

	localparam logic [CW-1:0] CNT_MUL_FIX  = CW'(GAIN_W);
	localparam logic [CW-1:0] CNT_MUL_LAST = CW'(MUL_LAST);
	localparam logic [CW-1:0] CNT_DIV_LAST = CW'(NW);

	localparam logic signed [DW-1:0]      D_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0]      D_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0]             HALF  = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DRIVE_W-1:0] O_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0] O_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

	// ------------------------------------------------------------------
	// Arithmetic helpers (all narrow: only adds, negations or compares in each)
	// ------------------------------------------------------------------
	function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW:0] s);
		if (s[DW] != s[DW-1]) begin
			return s[DW] ? D_MIN : D_MAX;
		end
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		return sat_sum((DW+1)'(a) + (DW+1)'(b));
	endfunction

	function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		return sat_sum((DW+1)'(a) - (DW+1)'(b));
	endfunction

	function automatic logic signed [DW-1:0] clamp_mag(input logic signed [DW-1:0] v,
			input logic [LIM_W-1:0] bound);
		logic signed [XW-1:0] vx;
		logic signed [XW-1:0] bx;
		logic signed [XW-1:0] nbx;
		vx  = XW'(v);
		bx  = signed'(XW'(bound));
		nbx = -bx;
		if (vx > bx) begin
			return bx[DW-1:0];
		end else if (vx < nbx) begin
			return nbx[DW-1:0];
		end
		return v;
	endfunction

	function automatic logic signed [DW-1:0] sat_in(input logic signed [ERR_W-1:0] e);
		logic signed [XW-1:0] ex;
		ex = XW'(e);
		if (ex > XW'(D_MAX)) begin
			return D_MAX;
		end else if (ex < XW'(D_MIN)) begin
			return D_MIN;
		end
		return ex[DW-1:0];
	endfunction

	function automatic logic signed [DRIVE_W-1:0] sat_out(input logic signed [DW-1:0] v);
		logic signed [XW-1:0] vx;
		vx = XW'(v);
		if (vx > XW'(O_MAX)) begin
			return O_MAX;
		end else if (vx < XW'(O_MIN)) begin
			return O_MIN;
		end
		return vx[DRIVE_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] mag_gain(input logic signed [GAIN_W-1:0] g);
		return g[GAIN_W-1] ? unsigned'(-g) : unsigned'(g);
	endfunction

	function automatic logic [DW-1:0] mag_data(input logic signed [DW-1:0] v);
		return v[DW-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	// drop the fraction bits, saturate the magnitude, apply the sign
	function automatic logic signed [DW-1:0] prod_fix(input logic [PW-1:0] p,
			input logic neg);
		logic [PW-FB-1:0] m;
		logic [DW-1:0]    lim;
		logic [DW-1:0]    mm;
		m   = p[PW-1:FB];
		lim = neg ? HALF : HALF - 1'b1;
		mm  = (m > (PW-FB)'(lim)) ? lim : m[DW-1:0];
		return neg ? signed'(-mm) : signed'(mm);
	endfunction

	function automatic logic signed [DW-1:0] quot_fix(input logic [NW-1:0] q,
			input logic neg);
		logic [DW-1:0] lim;
		logic [DW-1:0] mm;
		lim = neg ? HALF : HALF - 1'b1;
		mm  = (q > NW'(lim)) ? lim : q[DW-1:0];
		return neg ? signed'(-mm) : signed'(mm);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [GAIN_W-1:0] gain_p_q;
	logic signed [GAIN_W-1:0] gain_i_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic [LIM_W-1:0]         time_step_q;
	logic [LIM_W-1:0]         integ_limit_q;
	logic [LIM_W-1:0]         drive_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			time_step_q   <= TIME_STEP_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
			drive_limit_q <= DRIVE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:      gain_p_q      <= signed'(cfg_data[GAIN_W-1:0]);
				REG_GAIN_I:      gain_i_q      <= signed'(cfg_data[GAIN_W-1:0]);
				REG_GAIN_D:      gain_d_q      <= signed'(cfg_data[GAIN_W-1:0]);
				REG_TIME_STEP:   time_step_q   <= cfg_data[LIM_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[LIM_W-1:0];
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_data[LIM_W-1:0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// a zero step acts as the smallest step
	logic [LIM_W-1:0] tstep;
	assign tstep = (time_step_q == '0) ? LIM_W'(1) : time_step_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t            state_q;
	state_t            state_d;
	logic [CW-1:0]     cnt_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;
	logic              mul_start;

	// architectural state
	logic signed [DW-1:0] integ_q;
	logic signed [DW-1:0] prev_q;

	// working registers
	logic                   clr_q;
	logic signed [DW-1:0]   err_q;
	logic                   dneg_q;
	logic [NW-1:0]          dq_q;      // dividend bits out, quotient bits in
	logic [LIM_W-1:0]       rem_q;
	logic signed [DW-1:0]   deriv_q;
	logic [PW-1:0]          mul_q;     // product high part, multiplier bits low
	logic [DW-1:0]          mb_q;
	logic                   mneg_q;
	logic signed [DW-1:0]   pr_q;
	logic signed [DW-1:0]   acc_q;
	logic signed [DRIVE_W-1:0] drive_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (action == ACT_CLEAR) ? ST_FINISH : ST_PREP;
				end
			end
			ST_PREP:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_DIV_LAST) begin
					state_d = ST_MUL_DT;
				end
			end
			ST_MUL_DT: begin
				if (cnt_q == CNT_MUL_LAST) begin
					state_d = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				if (cnt_q == CNT_MUL_LAST) begin
					state_d = ST_MUL_I;
				end
			end
			ST_MUL_I: begin
				if (cnt_q == CNT_MUL_LAST) begin
					state_d = ST_MUL_D;
				end
			end
			ST_MUL_D: begin
				if (cnt_q == CNT_MUL_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// operands of the next product, picked by the state being entered
	logic signed [GAIN_W-1:0] op_a;
	logic signed [DW-1:0]     op_b;

	always_comb begin
		mul_start = 1'b0;
		op_a      = gain_p_q;
		op_b      = err_q;
		case (state_d)
			ST_MUL_DT: begin
				mul_start = (state_q != ST_MUL_DT);
				op_a      = signed'({1'b0, tstep});
				op_b      = err_q;
			end
			ST_MUL_P: begin
				mul_start = (state_q != ST_MUL_P);
				op_a      = gain_p_q;
				op_b      = err_q;
			end
			ST_MUL_I: begin
				mul_start = (state_q != ST_MUL_I);
				op_a      = gain_i_q;
				op_b      = integ_q;
			end
			ST_MUL_D: begin
				mul_start = (state_q != ST_MUL_D);
				op_a      = gain_d_q;
				op_b      = deriv_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Serial datapath steps
	// ------------------------------------------------------------------
	// multiplier: one multiplier bit per cycle, add multiplicand into the top
	logic [DW:0]   mul_add;
	logic [PW-1:0] mul_nxt;
	assign mul_add = {1'b0, mul_q[PW-1:GAIN_W]} + (mul_q[0] ? {1'b0, mb_q} : '0);
	assign mul_nxt = {mul_add, mul_q[GAIN_W-1:1]};

	// restoring divider: one quotient bit per cycle
	logic [LIM_W:0]   div_sh;
	logic [LIM_W+1:0] div_try;
	logic             div_ge;
	assign div_sh  = {rem_q, dq_q[NW-1]};
	assign div_try = {1'b0, div_sh} - {2'b00, tstep};
	assign div_ge  = !div_try[LIM_W+1];

	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] drive_sum;
	assign diff      = sat_sub(err_q, prev_q);
	assign drive_sum = sat_add(acc_q, pr_q);

	// ------------------------------------------------------------------
	// Control and architectural state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;
			// restart the step count on every state change
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q != ST_IDLE && state_q != ST_FINISH) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept && action == ACT_CLEAR) begin
				integ_q <= '0;
				prev_q  <= '0;
			end else begin
				// the difference is latched for the divider here, so advance now
				if (state_q == ST_PREP) begin
					prev_q <= err_q;
				end
				// anti-windup: saturate the sum, then clamp to the limit
				if (state_q == ST_MUL_DT && cnt_q == CNT_MUL_LAST) begin
					integ_q <= clamp_mag(sat_add(integ_q, pr_q), integ_limit_q);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Working registers (no reset needed)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= sat_in(error_in);
			clr_q <= (action == ACT_CLEAR);
		end

		case (state_q)
			ST_PREP: begin
				dneg_q <= diff[DW-1];
				dq_q   <= {mag_data(diff), {FB{1'b0}}};
				rem_q  <= '0;
			end
			ST_DIV: begin
				if (cnt_q == CNT_DIV_LAST) begin
					deriv_q <= quot_fix(dq_q, dneg_q);
				end else begin
					rem_q <= div_ge ? div_try[LIM_W-1:0] : div_sh[LIM_W-1:0];
					dq_q  <= {dq_q[NW-2:0], div_ge};
				end
			end
			ST_MUL_DT, ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
				if (cnt_q < CNT_MUL_FIX) begin
					mul_q <= mul_nxt;
				end else if (cnt_q == CNT_MUL_FIX) begin
					pr_q <= prod_fix(mul_q, mneg_q);
				end else if (cnt_q == CNT_MUL_LAST) begin
					// the drive sums as (P + I) + D, saturating at each add
					if (state_q == ST_MUL_P) begin
						acc_q <= pr_q;
					end else if (state_q == ST_MUL_I) begin
						acc_q <= drive_sum;
					end else if (state_q == ST_MUL_D) begin
						acc_q <= (drive_limit_q != '0) ? clamp_mag(drive_sum, drive_limit_q)
								: drive_sum;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					drive_q <= clr_q ? '0 : sat_out(acc_q);
				end
			end
			default: begin
				// idle: hold
			end
		endcase

		// load the next product's operands on entry to its state
		if (mul_start) begin
			mul_q  <= {{DW{1'b0}}, mag_gain(op_a)};
			mb_q   <= mag_data(op_b);
			mneg_q <= op_a[GAIN_W-1] ^ op_b[DW-1];
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_CLEAR) |=> (integ_q == '0 && prev_q == '0))
		else $error("clear request did not zero integrator and previous error");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	a_div_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (state_q == ST_DIV && cnt_q == '0 && rem_q == '0))
		else $error("divider did not start from a cleared remainder");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> !(accept && $past(state_d != ST_IDLE)))
		else $error("request accepted while a step is in progress");

endmodule
